/* design/stf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package stf_pkg;

	// Width of the value under test; the divisor stops one step past its square root
	localparam int VALUE_BITS  = 32;
	localparam int FACTOR_BITS = VALUE_BITS / 2 + 1;
	localparam int CNT_BITS    = $clog2(VALUE_BITS);

	// Port field widths
	localparam int NUMBER_W = 32;
	localparam int SMALL_W  = 16;
	localparam int LARGE_W  = 30;

	// First two trial divisors
	localparam logic [FACTOR_BITS-1:0] DIV_TWO   = FACTOR_BITS'(2);
	localparam logic [FACTOR_BITS-1:0] DIV_THREE = FACTOR_BITS'(3);

	typedef enum logic [1:0] {
		ST_SMALL   = 2'd0,
		ST_PRIME   = 2'd1,
		ST_NOSPLIT = 2'd2,
		ST_SPLIT   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ISSUE,
		CS_WAIT,
		CS_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic                   start;
		logic [VALUE_BITS-1:0]  dividend;
		logic [FACTOR_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic [VALUE_BITS-1:0]  quotient;
		logic [FACTOR_BITS-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic               valid;
		status_t            status;
		logic [SMALL_W-1:0] small_factor;
		logic [LARGE_W-1:0] large_factor;
	} res_t;

endpackage

`default_nettype wire

/* design/stf_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface stf_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

`default_nettype wire

/* design/stf_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface stf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] small_factor;
	logic [29:0] large_factor;

	modport source (output valid, output status, output small_factor, output large_factor,
		input ready);
	modport sink (input valid, input status, input small_factor, input large_factor,
		output ready);
endinterface

`default_nettype wire

/* design/stf_divider.sv */
`timescale 1ns / 1ps
`default_nettype none

module stf_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  stf_pkg::div_req_t req,
	output stf_pkg::div_rsp_t rsp
);
	import stf_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [VALUE_BITS-1:0]  work_q;
	logic [FACTOR_BITS-1:0] rem_q;
	logic [FACTOR_BITS-1:0] dsr_q;

	logic [FACTOR_BITS:0]   trial;
	logic [FACTOR_BITS:0]   diff;
	logic                   fits;
	logic [FACTOR_BITS-1:0] rem_next;
	logic                   launch;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	assign trial    = {rem_q, work_q[VALUE_BITS-1]};
	assign fits     = trial >= {1'b0, dsr_q};
	assign diff     = trial - {1'b0, dsr_q};
	assign rem_next = fits ? diff[FACTOR_BITS-1:0] : trial[FACTOR_BITS-1:0];
	assign launch   = req.start && !busy_q;

	// Sequence the bit steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (launch) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(VALUE_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift dividend out and quotient bits in through one register
	always_ff @(posedge clk) begin
		if (launch) begin
			work_q <= req.dividend;
			rem_q  <= '0;
			dsr_q  <= req.divisor;
		end else if (busy_q) begin
			work_q <= {work_q[VALUE_BITS-2:0], fits};
			rem_q  <= rem_next;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = work_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

/* design/stf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module stf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	stf_in_if.sink            item,
	output stf_pkg::div_req_t div_req,
	input  stf_pkg::div_rsp_t div_rsp,
	output stf_pkg::res_t     res,
	input  logic              res_ready
);
	import stf_pkg::*;

	ctrl_state_t            state_q, state_d;
	logic                   phase_q, phase_d;
	logic [VALUE_BITS-1:0]  n_q, n_d;
	logic [FACTOR_BITS-1:0] d_q, d_d;
	logic [FACTOR_BITS-1:0] p_q, p_d;
	status_t                status_q, status_d;
	logic [SMALL_W-1:0]     small_q, small_d;
	logic [LARGE_W-1:0]     large_q, large_d;

	logic [VALUE_BITS-1:0]  raw;
	logic                   too_small;
	logic                   past_root;
	logic                   divides;

	assign raw       = VALUE_BITS'($unsigned(item.number));
	assign too_small = raw[VALUE_BITS-1] || (raw <= VALUE_BITS'(1));
	assign past_root = VALUE_BITS'(d_q) > div_rsp.quotient;
	assign divides   = div_rsp.remainder == '0;

	// Next state: phase 0 searches the smallest factor, phase 1 tests the cofactor
	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		n_d      = n_q;
		d_d      = d_q;
		p_d      = p_q;
		status_d = status_q;
		small_d  = small_q;
		large_d  = large_q;
		unique case (state_q)
			CS_IDLE: begin
				if (item.valid) begin
					small_d = '0;
					large_d = '0;
					n_d     = raw;
					d_d     = DIV_TWO;
					phase_d = 1'b0;
					if (too_small) begin
						status_d = ST_SMALL;
						state_d  = CS_DONE;
					end else begin
						state_d = CS_ISSUE;
					end
				end
			end
			CS_ISSUE: begin
				state_d = CS_WAIT;
			end
			CS_WAIT: begin
				if (div_rsp.done) begin
					priority if (past_root) begin
						// No divisor up to the root: the value under test is prime
						if (!phase_q) begin
							status_d = ST_PRIME;
						end else begin
							status_d = ST_SPLIT;
							small_d  = SMALL_W'(p_q);
							large_d  = LARGE_W'(n_q);
						end
						state_d = CS_DONE;
					end else if (divides) begin
						if (!phase_q) begin
							p_d     = d_q;
							n_d     = div_rsp.quotient;
							d_d     = DIV_TWO;
							phase_d = 1'b1;
							state_d = CS_ISSUE;
						end else begin
							status_d = ST_NOSPLIT;
							state_d  = CS_DONE;
						end
					end else begin
						d_d     = (d_q == DIV_TWO) ? DIV_THREE : FACTOR_BITS'(d_q + DIV_TWO);
						state_d = CS_ISSUE;
					end
				end
			end
			CS_DONE: begin
				if (res_ready) begin
					state_d = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// Working values and result
	always_ff @(posedge clk) begin
		n_q      <= n_d;
		d_q      <= d_d;
		p_q      <= p_d;
		status_q <= status_d;
		small_q  <= small_d;
		large_q  <= large_d;
	end

	assign item.ready       = state_q == CS_IDLE;
	assign div_req.start    = state_q == CS_ISSUE;
	assign div_req.dividend = n_q;
	assign div_req.divisor  = d_q;

	assign res.valid        = state_q == CS_DONE;
	assign res.status       = status_q;
	assign res.small_factor = small_q;
	assign res.large_factor = large_q;

endmodule

`default_nettype wire

/* design/semiprime_trial_factor.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                      Transfer
// item     in   number (32, signed)                          valid & ready
// result   out  status (2), small_factor (16),               valid & ready
//               large_factor (30)
//
// Each trial division runs on one shared bit-serial divider: an issue state,
// 32 bit steps, then a decision in the wait state, per trial divisor.
// An item that is too small never reaches the divider; a 31-bit prime takes the most
// trial divisors (about 23k); a split or its absence takes fewer.
// One item at a time; the next one is taken while a result waits in the output register.
// Reset clears the sequencer and the output valid; no clearing pass.
module semiprime_trial_factor (
	input  logic      clk,
	input  logic      arst_n,
	stf_in_if.sink    item,
	stf_out_if.source result
);
	import stf_pkg::*;

	div_req_t div_req;
	div_rsp_t div_rsp;
	res_t     res;
	logic     res_ready;

	logic               valid_q;
	status_t            status_q;
	logic [SMALL_W-1:0] small_q;
	logic [LARGE_W-1:0] large_q;

	stf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.res       (res),
		.res_ready (res_ready)
	);

	stf_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Output register: load when empty or draining this cycle
	assign res_ready = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			status_q <= res.status;
			small_q  <= res.small_factor;
			large_q  <= res.large_factor;
		end
	end

	assign result.valid        = valid_q;
	assign result.status       = status_q;
	assign result.small_factor = small_q;
	assign result.large_factor = large_q;

`ifndef SYNTHESIS
	// A split reports two real factors, smaller first
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == ST_SPLIT) |->
		(result.small_factor >= 16'd2 && 30'(result.small_factor) <= result.large_factor))
		else $error("split factors out of order or too small");

	// Any other outcome carries zero factors
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status != ST_SPLIT) |->
		(result.small_factor == '0 && result.large_factor == '0))
		else $error("nonzero factor on a non-split result");

	// One item at a time: no second transfer right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("input taken while an item is in work");

	// The divider is never started while the input side is open
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !item.ready)
		else $error("divider started while idle");
`endif

endmodule

`default_nettype wire
